// ===== sv/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants of the transport-message reassembler: word
// layouts of both channels, store sizing and the request bundle of the store.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // Store sizing
  localparam int MAX_PACKETS      = 32;
  localparam int BYTES_PER_PACKET = 7;
  localparam int ADDR_W           = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int CNT_W            = $clog2(MAX_PACKETS + 1);

  // Field widths
  localparam int CHUNK_W     = 56;
  localparam int CHUNK_IDX_W = 6;
  localparam int SIZE_W      = 11;
  localparam int PGN_W       = 18;
  localparam int BYTES_W     = 3;

  // Item kinds
  localparam logic KIND_ANNOUNCE = 1'b0;
  localparam logic KIND_DATA     = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         source_address;
    logic [7:0]         seq_num;
    logic [CHUNK_W-1:0] payload;
    logic [7:0]         packet_count;
    logic [SIZE_W-1:0]  message_size;
    logic [PGN_W-1:0]   message_pgn;
    logic               is_rts;
  } tpr_in_t;

  typedef struct packed {
    logic [CHUNK_W-1:0]     chunk;
    logic [BYTES_W-1:0]     chunk_bytes;
    logic [CHUNK_IDX_W-1:0] chunk_index;
    logic                   last;
    logic [PGN_W-1:0]       out_pgn;
    logic [7:0]             sender;
    logic                   send_end_ack;
    logic                   announce_refused;
  } tpr_out_t;

  // Access request from the sequencer to the chunk store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              clear;
  } tpr_store_req_t;

endpackage

// ===== sv/tpr_if.sv =====
// ----------------------------------------------------------------------------
// tpr_in_if / tpr_out_if
// Valid/ready channels of the reassembler; a word moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tpr_in_if;
  import tpr_pkg::*;

  logic    valid;
  logic    ready;
  tpr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpr_out_if;
  import tpr_pkg::*;

  logic     valid;
  logic     ready;
  tpr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tpr_store.sv =====
// ----------------------------------------------------------------------------
// tpr_store
// Chunk store: one write port, one read port with registered read data, and
// a valid bit per slot so that an unwritten or cleared slot reads as zero.
// ----------------------------------------------------------------------------
module tpr_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpr_pkg::tpr_store_req_t        req,
  input  logic [tpr_pkg::CHUNK_W-1:0]    wr_data,
  output logic [tpr_pkg::CHUNK_W-1:0]    rd_data
);
  import tpr_pkg::*;

  logic [CHUNK_W-1:0]     mem [MAX_PACKETS];
  logic [MAX_PACKETS-1:0] slot_valid_r;
  logic [MAX_PACKETS-1:0] slot_valid_nxt;
  logic [CHUNK_W-1:0]     rd_word_r;
  logic                   rd_hit_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  // Track written slots; drop them all on clear
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (req.clear) begin
      slot_valid_nxt = '0;
    end else if (req.wr_en) begin
      slot_valid_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      rd_hit_r     <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      if (req.rd_en) begin
        rd_hit_r <= slot_valid_r[req.rd_addr];
      end
    end
  end

  // Mask slots never written since the last clear
  assign rd_data = rd_hit_r ? rd_word_r : '0;

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr_en && req.clear))
    else $error("store written in the cycle it is cleared");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.clear |=> slot_valid_r == '0)
    else $error("slot valid bits left set after clear");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |=> slot_valid_r[$past(req.wr_addr)])
    else $error("written slot not marked valid");

endmodule

// ===== sv/tp_packet_reassembler.sv =====
// ----------------------------------------------------------------------------
// tp_packet_reassembler
// Receive side of a multi-packet transport session: collects data packets in
// a chunk store and streams the message out as 7-byte chunks on completion.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries announce and data words; out_ch carries result words.
//   in_ch.ready is high whenever no completion burst or refusal is pending.
//   An announce that is not refused, or a data word that does not complete the
//   message, leaves the block idle; it is ready again in the next cycle.
//   A refused announce (count above the store depth) gives one result word,
//   loaded into the output register in the cycle after acceptance, or later
//   while the output register still holds an untaken word.
//   A completing data word starts a burst: the sequencer enters the dump state,
//   issues store reads and loads the read data into the output register when it
//   is free, one chunk per cycle while out_ch.ready is high, paced by the single
//   read port of the store. A completion keeps in_ch.ready low until the final
//   chunk is loaded into the output register.
//   A stalled receiver holds the output register; the store read pipeline
//   stops with it and no chunk is lost or repeated.
//   Reset clears the session and the per-slot valid bits at once, so the
//   store needs no clearing pass; unwritten slots read as zero.
// ----------------------------------------------------------------------------
module tp_packet_reassembler (
  input  logic     clk,
  input  logic     rst_n,
  tpr_in_if.sink   in_ch,
  tpr_out_if.source out_ch
);
  import tpr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_DUMP   = 2'd2;

  localparam logic [7:0] SEQ_MAX = 8'(MAX_PACKETS);

  logic [1:0]         state_r,     state_nxt;
  logic [CNT_W-1:0]   exp_cnt_r,   exp_cnt_nxt;
  logic [SIZE_W-1:0]  exp_size_r,  exp_size_nxt;
  logic [PGN_W-1:0]   pgn_r,       pgn_nxt;
  logic               rts_r,       rts_nxt;
  logic [7:0]         sender_r,    sender_nxt;
  logic [CNT_W-1:0]   rd_cnt_r,    rd_cnt_nxt;
  logic               pend_r,      pend_nxt;
  logic [ADDR_W-1:0]  pend_idx_r,  pend_idx_nxt;
  tpr_out_t           out_r,       out_nxt;
  logic               out_valid_r, out_valid_nxt;

  tpr_store_req_t     store_req;
  logic [CHUNK_W-1:0] store_rd_data;

  logic               in_fire;
  logic               is_data;
  logic               seq_ok;
  logic               refuse;
  logic               complete;
  logic               out_free;
  logic               load;
  logic               issue;
  logic               last_load;
  logic [SIZE_W-1:0]  chunk_start;
  logic [SIZE_W-1:0]  chunk_remain;
  logic [BYTES_W-1:0] chunk_bytes;

  // Decode the incoming word
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_data  = (in_ch.data.kind == KIND_DATA);
  assign seq_ok   = (in_ch.data.seq_num != 8'd0) &&
                    (in_ch.data.seq_num <= SEQ_MAX);
  assign refuse   = !is_data && (in_ch.data.packet_count > SEQ_MAX);
  assign complete = is_data && seq_ok && (exp_cnt_r != '0) &&
                    (in_ch.data.seq_num == 8'(exp_cnt_r));

  // Burst read pipeline: issue a read only when its data has a place to go
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load      = pend_r && out_free;
  assign issue     = (state_r == ST_DUMP) && (rd_cnt_r < exp_cnt_r) && (!pend_r || load);
  assign last_load = load &&
                     ((CNT_W'(pend_idx_r) + CNT_W'(1)) == exp_cnt_r);

  // Store access
  always_comb begin
    store_req         = '0;
    store_req.wr_en   = in_fire && is_data && seq_ok;
    store_req.wr_addr = ADDR_W'(in_ch.data.seq_num - 8'd1);
    store_req.rd_en   = issue;
    store_req.rd_addr = ADDR_W'(rd_cnt_r);
    store_req.clear   = last_load;
  end

  tpr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .wr_data (in_ch.data.payload),
    .rd_data (store_rd_data)
  );

  // Count the bytes of the pending chunk that lie within the message
  always_comb begin
    chunk_start  = SIZE_W'(pend_idx_r) * SIZE_W'(BYTES_PER_PACKET);
    chunk_remain = exp_size_r - chunk_start;
    if (exp_size_r <= chunk_start) begin
      chunk_bytes = '0;
    end else if (chunk_remain > SIZE_W'(BYTES_PER_PACKET)) begin
      chunk_bytes = BYTES_W'(BYTES_PER_PACKET);
    end else begin
      chunk_bytes = chunk_remain[BYTES_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    exp_cnt_nxt   = exp_cnt_r;
    exp_size_nxt  = exp_size_r;
    pgn_nxt       = pgn_r;
    rts_nxt       = rts_r;
    sender_nxt    = sender_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // Retire the word taken by the receiver
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_data) begin
            if (refuse) begin
              state_nxt = ST_REFUSE;
            end else begin
              exp_cnt_nxt  = CNT_W'(in_ch.data.packet_count);
              exp_size_nxt = in_ch.data.message_size;
              pgn_nxt      = in_ch.data.message_pgn;
              rts_nxt      = in_ch.data.is_rts;
            end
          end else if (complete) begin
            state_nxt  = ST_DUMP;
            sender_nxt = in_ch.data.source_address;
            rd_cnt_nxt = '0;
            pend_nxt   = 1'b0;
          end
        end
      end
      ST_REFUSE: begin
        if (out_free) begin
          out_nxt                  = '0;
          out_nxt.announce_refused = 1'b1;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (issue) begin
          rd_cnt_nxt   = CNT_W'(rd_cnt_r + CNT_W'(1));
          pend_idx_nxt = ADDR_W'(rd_cnt_r);
        end
        if (load) begin
          out_nxt.chunk            = store_rd_data;
          out_nxt.chunk_bytes      = chunk_bytes;
          out_nxt.chunk_index      = CHUNK_IDX_W'(pend_idx_r);
          out_nxt.last             = last_load;
          out_nxt.out_pgn          = pgn_r;
          out_nxt.sender           = sender_r;
          out_nxt.send_end_ack     = rts_r;
          out_nxt.announce_refused = 1'b0;
          out_valid_nxt            = 1'b1;
        end
        if (issue) begin
          pend_nxt = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        // Drop the session once the final chunk is loaded into the output register
        if (last_load) begin
          state_nxt    = ST_IDLE;
          exp_cnt_nxt  = '0;
          exp_size_nxt = '0;
          pgn_nxt      = '0;
          rts_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_cnt_r   <= '0;
      exp_size_r  <= '0;
      pgn_r       <= '0;
      rts_r       <= 1'b0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      exp_size_r  <= exp_size_nxt;
      pgn_r       <= pgn_nxt;
      rts_r       <= rts_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sender_r   <= sender_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r      <= out_nxt;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.announce_refused |->
      out_ch.data.chunk == '0 && out_ch.data.chunk_index == '0 && !out_ch.data.last)
    else $error("refusal word carries chunk data");

  a_session_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    last_load |=> exp_cnt_r == '0 && state_r == ST_IDLE && !pend_r)
    else $error("session not dropped after final chunk");

  a_pend_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_DUMP)
    else $error("store read pending outside a burst");

  a_last_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> CNT_W'(pend_idx_r) < exp_cnt_r && rd_cnt_r <= exp_cnt_r)
    else $error("chunk index beyond announced count");

endmodule
